// File: design/aer_event_word_decoder_unit_defines.svh
// assertion macros for the aer event word decoder
// used by the top level; expects clk and arst_n in scope at the point of use
`ifndef AER_EVENT_WORD_DECODER_UNIT_DEFINES_SVH
`define AER_EVENT_WORD_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define AER_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AER_ASSERT_NOW(label, ante, cons, msg)
`define AER_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: design/aer_pkg.sv
// types and constants for the aer event word decoder
// no dependencies; used by aer_classify and aer_event_word_decoder_unit
`timescale 1ns / 1ps

package aer_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned STAMP_W = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COORD_W = 6;

	localparam logic [DATA_W-1:0]  OVF_CODE    = 16'hFFFF;
	localparam logic [DATA_W-1:0]  PULSE_DOWN  = 16'h1000;
	localparam logic [DATA_W-1:0]  PULSE_UP    = 16'h1001;
	localparam logic [COORD_W-1:0] PULSE_COORD = 6'd35;
	localparam logic [TIME_W-1:0]  OVF_STEP    = 32'h0001_0000;
	localparam logic [TIME_W-1:0]  COUNT_ONE   = 32'd1;

	typedef enum logic [1:0] {
		KIND_OVERFLOW = 2'd0,
		KIND_PULSE    = 2'd1,
		KIND_ADDRESS  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_base;
		logic [TIME_W-1:0] event_count;
		logic [TIME_W-1:0] overflow_count;
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [TIME_W-1:0]  event_time;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic               polarity;
		logic               invalid;
		logic [TIME_W-1:0]  event_total;
		logic [TIME_W-1:0]  overflow_total;
	} result_t;

endpackage

// File: design/aer_classify.sv
// decode of one event word against the running time base and counters
// depends on aer_pkg
`timescale 1ns / 1ps

module aer_classify (
	input  logic [aer_pkg::DATA_W-1:0]  event_data,
	input  logic [aer_pkg::STAMP_W-1:0] event_stamp,
	input  aer_pkg::state_t             cur,
	output aer_pkg::state_t             nxt,
	output aer_pkg::result_t            res
);
	import aer_pkg::*;

	logic is_ovf;
	logic is_pulse;

	assign is_ovf   = (event_data == OVF_CODE) && (event_stamp == OVF_CODE);
	assign is_pulse = (event_data == PULSE_DOWN) || (event_data == PULSE_UP);

	always_comb begin
		nxt = cur;
		res = '0;
		priority if (is_ovf) begin
			nxt.time_base      = cur.time_base + OVF_STEP;
			nxt.overflow_count = cur.overflow_count + COUNT_ONE;
			res.kind           = KIND_OVERFLOW;
			res.event_time     = nxt.time_base;
		end else if (is_pulse) begin
			nxt.event_count = cur.event_count + COUNT_ONE;
			res.kind        = KIND_PULSE;
			res.event_time  = cur.time_base + {{(TIME_W-STAMP_W){1'b0}}, event_stamp};
			res.x_coord     = PULSE_COORD;
			res.y_coord     = PULSE_COORD;
			res.polarity    = (event_data == PULSE_UP);
		end else begin
			nxt.event_count = cur.event_count + COUNT_ONE;
			res.kind        = KIND_ADDRESS;
			res.event_time  = cur.time_base + {{(TIME_W-STAMP_W){1'b0}}, event_stamp};
			res.x_coord     = {1'b0, event_data[4:0]};
			res.y_coord     = {1'b0, event_data[10:6]};
			res.polarity    = event_data[5];
			res.invalid     = event_data[5] ^ event_data[11];
		end
		res.event_total    = nxt.event_count;
		res.overflow_total = nxt.overflow_count;
	end

endmodule

// File: design/aer_event_word_decoder_unit.sv
// top level of the aer event word decoder: input register, decode, result register
// depends on aer_pkg, aer_classify and aer_event_word_decoder_unit_defines.svh
`timescale 1ns / 1ps
`include "aer_event_word_decoder_unit_defines.svh"

// Decodes one 32-bit sensor event word per transaction (data half and timestamp half)
// into a kind, an absolute 32-bit time, x/y/polarity and running event and overflow
// totals. Throughput is one word per clock while results are taken. A word accepted
// into the input register is decoded combinationally and loaded into the result
// register, which drives result_valid. When both registers are full and result_stall
// is high, event_stall follows it in the same cycle. The time base and counters
// update when a word moves into the result register, so they always match the
// delivered order. A word with both halves 0xFFFF advances the time base by 65536.
// The valid flags, time base and counters reset to zero on arst_n; data registers do not.
module aer_event_word_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        event_valid,
	output logic                        event_stall,
	input  logic [aer_pkg::DATA_W-1:0]  event_data,
	input  logic [aer_pkg::STAMP_W-1:0] event_stamp,
	output logic                        result_valid,
	input  logic                        result_stall,
	output aer_pkg::kind_t              kind,
	output logic [aer_pkg::TIME_W-1:0]  event_time,
	output logic [aer_pkg::COORD_W-1:0] x_coord,
	output logic [aer_pkg::COORD_W-1:0] y_coord,
	output logic                        polarity,
	output logic                        invalid,
	output logic [aer_pkg::TIME_W-1:0]  event_total,
	output logic [aer_pkg::TIME_W-1:0]  overflow_total
);
	import aer_pkg::*;

	logic                 valid_s1;
	logic [DATA_W-1:0]    data_s1;
	logic [STAMP_W-1:0]   stamp_s1;
	logic                 out_blocked;
	logic                 advance;
	state_t               state_q;
	state_t               state_nxt;
	result_t              res_d;
	result_t              res_q;
	logic                 valid_q;

	assign out_blocked = valid_q && result_stall;
	assign advance     = valid_s1 && !out_blocked;
	assign event_stall = valid_s1 && out_blocked;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!event_stall) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_valid && !event_stall) begin
			data_s1  <= event_data;
			stamp_s1 <= event_stamp;
		end
	end

	aer_classify u_classify (
		.event_data  (data_s1),
		.event_stamp (stamp_s1),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res_d)
	);

	// time base and counters commit with the result register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result_valid   = valid_q;
	assign kind           = res_q.kind;
	assign event_time     = res_q.event_time;
	assign x_coord        = res_q.x_coord;
	assign y_coord        = res_q.y_coord;
	assign polarity       = res_q.polarity;
	assign invalid        = res_q.invalid;
	assign event_total    = res_q.event_total;
	assign overflow_total = res_q.overflow_total;

	`AER_ASSERT_NOW(a_stall_needs_word, event_stall, valid_s1 && valid_q, "stall without held word")
	`AER_ASSERT_NOW(a_ovf_fields_zero, result_valid && (kind == KIND_OVERFLOW), (x_coord == '0) && (y_coord == '0) && !polarity && !invalid, "overflow result carries address fields")
	`AER_ASSERT_NOW(a_pulse_coords, result_valid && (kind == KIND_PULSE), (x_coord == PULSE_COORD) && (y_coord == PULSE_COORD) && !invalid, "test pulse coordinates wrong")
	`AER_ASSERT_NEXT(a_totals_step, result_valid && !result_stall, !result_valid || (TIME_W'(event_total + overflow_total) == TIME_W'($past(event_total) + $past(overflow_total) + COUNT_ONE)), "totals did not advance by one")

endmodule
